// ----- rtl/core/urns_pkg.sv -----
// urns_pkg: shared widths, latencies, types and register codes of the node score unit
// no dependencies; imported by every module in rtl/core
package urns_pkg;

    // field widths
    localparam int VISIT_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 16;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [CFG_W-1:0] EXPLORE_WEIGHT_RST = 16'd1638;
    localparam logic [CFG_W-1:0] RAVE_K_RST         = 16'd50;

    typedef enum logic {
        REG_EXPLORE_WEIGHT = 1'b0,
        REG_RAVE_K         = 1'b1
    } t_reg_idx;

    // log2 in q5.24 from a q1.31 mantissa
    localparam int LOG_FRAC = 24;
    localparam int MANT_W   = 32;
    localparam int SH_W     = $clog2(MANT_W);
    localparam int P_W      = $clog2(VISIT_BITS);
    localparam int LOG_W    = P_W + LOG_FRAC;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int LN_W     = 32 + P_W;

    // exploration radicand and root
    localparam int RAD_SHIFT  = 17;
    localparam int RAD_W      = LN_W + RAD_SHIFT;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int TERM_SHIFT = 36 - FRAC_BITS;
    localparam int TERM_W     = CFG_W + ROOT_W - TERM_SHIFT;

    // beta weight in q.24
    localparam int BETA_FRAC = 24;
    localparam int BETA_W    = BETA_FRAC + 1;
    localparam int BDEN_W    = VISIT_BITS + 2;
    localparam int BRAD_W    = 2 * BETA_FRAC;

    // blend
    localparam int Q_W   = DATA_W + 2;
    localparam int P1_W  = BETA_W + 1 + Q_W;
    localparam int P2_W  = BETA_FRAC + 1 + DATA_W;
    localparam int ACC_W = P1_W + 1;
    localparam int SH_OUT_W = ACC_W - BETA_FRAC;

    // pipeline latencies of the three paths
    localparam int EXP_LAT   = 1 + LOG_FRAC + 1 + RAD_W + ROOT_W + 1;
    localparam int MEAN_LAT  = DATA_W + 2;
    localparam int BETA_LAT  = 1 + BRAD_W + BETA_FRAC;
    localparam int MEAN_DLY  = EXP_LAT - MEAN_LAT;
    localparam int BETA_DLY  = EXP_LAT - BETA_LAT;
    localparam int TOTAL_LAT = EXP_LAT + 3;

    // control that travels with each word
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

// ----- rtl/core/urns_mean_pipe.sv -----
// urns_mean_pipe: two lanes of signed-by-unsigned division, one quotient bit per stage
// depends on urns_pkg
module urns_mean_pipe (
    input  logic                                   i_clk,
    input  logic                                   i_adv,
    input  logic signed [urns_pkg::DATA_W-1:0]     i_child_score,
    input  logic [urns_pkg::VISIT_BITS-1:0]        i_child_visits,
    input  logic signed [urns_pkg::DATA_W-1:0]     i_amaf_reward,
    input  logic [urns_pkg::VISIT_BITS-1:0]        i_amaf_visits,
    output logic signed [urns_pkg::DATA_W-1:0]     o_score_mean,
    output logic signed [urns_pkg::DATA_W-1:0]     o_reward_mean
);
    import urns_pkg::*;

    localparam int LANES = 2;

    logic [DATA_W-1:0]     w_num [LANES];
    logic [VISIT_BITS-1:0] w_den [LANES];

    logic [DATA_W-1:0]        r_dq   [LANES][0:DATA_W];
    logic [VISIT_BITS-1:0]    r_rem  [LANES][0:DATA_W];
    logic [VISIT_BITS-1:0]    r_den  [LANES][0:DATA_W];
    logic                     r_neg  [LANES][0:DATA_W];
    logic signed [DATA_W-1:0] r_mean [LANES];

    // lane inputs
    assign w_num[0] = i_child_score;
    assign w_den[0] = i_child_visits;
    assign w_num[1] = i_amaf_reward;
    assign w_den[1] = i_amaf_visits;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        // entry: magnitude and sign
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dq[l][0]  <= w_num[l][DATA_W-1] ? (DATA_W'(0) - w_num[l]) : w_num[l];
                r_rem[l][0] <= '0;
                r_den[l][0] <= w_den[l];
                r_neg[l][0] <= w_num[l][DATA_W-1];
            end
        end

        // restoring division, one quotient bit per stage
        for (genvar k = 0; k < DATA_W; k++) begin : g_step
            logic [VISIT_BITS:0] w_t;
            logic [VISIT_BITS:0] w_d;
            logic                w_ge;

            assign w_t  = {r_rem[l][k], r_dq[l][k][DATA_W-1]};
            assign w_ge = (w_t >= {1'b0, r_den[l][k]});
            assign w_d  = w_t - {1'b0, r_den[l][k]};

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[l][k+1] <= w_ge ? w_d[VISIT_BITS-1:0] : w_t[VISIT_BITS-1:0];
                    r_dq[l][k+1]  <= {r_dq[l][k][DATA_W-2:0], w_ge};
                    r_den[l][k+1] <= r_den[l][k];
                    r_neg[l][k+1] <= r_neg[l][k];
                end
            end
        end

        // sign back on, truncation toward zero
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_mean[l] <= $signed(r_neg[l][DATA_W] ? (DATA_W'(0) - r_dq[l][DATA_W])
                                                      : r_dq[l][DATA_W]);
            end
        end
    end

    assign o_score_mean  = r_mean[0];
    assign o_reward_mean = r_mean[1];

endmodule

// ----- rtl/core/urns_beta_pipe.sv -----
// urns_beta_pipe: beta = sqrt(K / (3N + K)) in q.24, divider stages then root stages
// depends on urns_pkg
module urns_beta_pipe (
    input  logic                              i_clk,
    input  logic                              i_adv,
    input  logic [urns_pkg::VISIT_BITS-1:0]   i_parent_visits,
    input  logic [urns_pkg::CFG_W-1:0]        i_rave_k,
    output logic [urns_pkg::BETA_FRAC-1:0]    o_beta
);
    import urns_pkg::*;

    logic [BDEN_W-1:0] r_bd_den [0:BRAD_W];
    logic [BDEN_W-1:0] r_bd_rem [0:BRAD_W];
    logic [BRAD_W-1:0] r_bd_q   [0:BRAD_W];

    logic [BRAD_W-1:0]    r_bs_x    [1:BETA_FRAC];
    logic [BETA_FRAC:0]   r_bs_rem  [1:BETA_FRAC];
    logic [BETA_FRAC-1:0] r_bs_root [1:BETA_FRAC];

    // entry: denominator 3N + K, remainder starts at K
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bd_den[0] <= BDEN_W'(i_parent_visits) + BDEN_W'({i_parent_visits, 1'b0})
                         + BDEN_W'(i_rave_k);
            r_bd_rem[0] <= BDEN_W'(i_rave_k);
            r_bd_q[0]   <= '0;
        end
    end

    // fraction bits of K / (3N + K)
    for (genvar k = 0; k < BRAD_W; k++) begin : g_div
        logic [BDEN_W:0] w_t;
        logic [BDEN_W:0] w_d;
        logic            w_ge;

        assign w_t  = {r_bd_rem[k], 1'b0};
        assign w_ge = (w_t >= {1'b0, r_bd_den[k]});
        assign w_d  = w_t - {1'b0, r_bd_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_bd_rem[k+1] <= w_ge ? w_d[BDEN_W-1:0] : w_t[BDEN_W-1:0];
                r_bd_q[k+1]   <= {r_bd_q[k][BRAD_W-2:0], w_ge};
                r_bd_den[k+1] <= r_bd_den[k];
            end
        end
    end

    // floor square root, one root bit per stage
    for (genvar j = 0; j < BETA_FRAC; j++) begin : g_root
        logic [BRAD_W-1:0]    w_x;
        logic [BETA_FRAC:0]   w_rem;
        logic [BETA_FRAC-1:0] w_root;
        logic [BETA_FRAC+2:0] w_t;
        logic [BETA_FRAC+2:0] w_trial;
        logic [BETA_FRAC+2:0] w_d;
        logic                 w_ge;

        if (j == 0) begin : g_first
            assign w_x    = r_bd_q[BRAD_W];
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_x    = r_bs_x[j];
            assign w_rem  = r_bs_rem[j];
            assign w_root = r_bs_root[j];
        end

        assign w_t     = {w_rem, w_x[BRAD_W-1:BRAD_W-2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_ge    = (w_t >= w_trial);
        assign w_d     = w_t - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_bs_x[j+1]    <= {w_x[BRAD_W-3:0], 2'b00};
                r_bs_rem[j+1]  <= w_ge ? w_d[BETA_FRAC:0] : w_t[BETA_FRAC:0];
                r_bs_root[j+1] <= {w_root[BETA_FRAC-2:0], w_ge};
            end
        end
    end

    assign o_beta = r_bs_root[BETA_FRAC];

endmodule

// ----- rtl/core/urns_explore_pipe.sv -----
// urns_explore_pipe: exploration term C * sqrt(2 ln(Np) / n), log, ln, divide, root, scale
// depends on urns_pkg; carries the valid and zero-visit control of each word
module urns_explore_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  urns_pkg::t_ctl                    i_ctl,
    input  logic [urns_pkg::VISIT_BITS-1:0]   i_child_visits,
    input  logic [urns_pkg::VISIT_BITS-1:0]   i_parent_visits,
    input  logic [urns_pkg::CFG_W-1:0]        i_explore_weight,
    output urns_pkg::t_ctl                    o_ctl,
    output logic [urns_pkg::TERM_W-1:0]       o_term
);
    import urns_pkg::*;

    logic [P_W-1:0]    w_msb;
    logic [MANT_W-1:0] w_norm;
    logic [LOG_W+31:0] w_lnp;
    logic [CFG_W+ROOT_W-1:0] w_tp;

    // log stages: index 0 is the normalized mantissa
    logic [MANT_W-1:0]     r_lg_x   [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]   r_lg_f   [0:LOG_FRAC];
    logic [P_W-1:0]        r_lg_p   [0:LOG_FRAC];
    logic [VISIT_BITS-1:0] r_lg_n   [0:LOG_FRAC];
    t_ctl                  r_lg_ctl [0:LOG_FRAC];

    // divider stages: index 0 holds ln << 17
    logic [RAD_W-1:0]      r_dv_dq  [0:RAD_W];
    logic [VISIT_BITS-1:0] r_dv_rem [0:RAD_W];
    logic [VISIT_BITS-1:0] r_dv_n   [0:RAD_W];
    t_ctl                  r_dv_ctl [0:RAD_W];

    // root stages
    logic [2*ROOT_W-1:0] r_sr_x    [1:ROOT_W];
    logic [ROOT_W:0]     r_sr_rem  [1:ROOT_W];
    logic [ROOT_W-1:0]   r_sr_root [1:ROOT_W];
    t_ctl                r_sr_ctl  [1:ROOT_W];

    logic [TERM_W-1:0] r_term;
    t_ctl              r_term_ctl;

    // leading one of the parent count
    always_comb begin
        w_msb = '0;
        for (int b = 0; b < VISIT_BITS; b++) begin
            if (i_parent_visits[b]) begin
                w_msb = P_W'(b);
            end
        end
    end

    assign w_norm = MANT_W'(i_parent_visits) << (SH_W'(MANT_W - 1) - SH_W'(w_msb));

    // normalize into q1.31
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_ctl[0] <= '0;
        end else if (i_adv) begin
            r_lg_ctl[0] <= i_ctl;
            r_lg_x[0]   <= w_norm;
            r_lg_f[0]   <= '0;
            r_lg_p[0]   <= w_msb;
            r_lg_n[0]   <= i_child_visits;
        end
    end

    // one fraction bit of log2 per squaring stage
    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
        logic [2*MANT_W-1:0] w_prod;
        logic [MANT_W:0]     w_sq;

        assign w_prod = r_lg_x[k] * r_lg_x[k];
        assign w_sq   = w_prod[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_ctl[k+1] <= '0;
            end else if (i_adv) begin
                r_lg_ctl[k+1] <= r_lg_ctl[k];
                r_lg_x[k+1]   <= w_sq[MANT_W] ? w_sq[MANT_W:1] : w_sq[MANT_W-1:0];
                r_lg_f[k+1]   <= {r_lg_f[k][LOG_FRAC-2:0], w_sq[MANT_W]};
                r_lg_p[k+1]   <= r_lg_p[k];
                r_lg_n[k+1]   <= r_lg_n[k];
            end
        end
    end

    // natural log in q.32, scaled for the divider
    assign w_lnp = {r_lg_p[LOG_FRAC], r_lg_f[LOG_FRAC]} * LN2_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ctl[0] <= '0;
        end else if (i_adv) begin
            r_dv_ctl[0] <= r_lg_ctl[LOG_FRAC];
            r_dv_dq[0]  <= {w_lnp[LOG_W+31 -: LN_W], {RAD_SHIFT{1'b0}}};
            r_dv_rem[0] <= '0;
            r_dv_n[0]   <= r_lg_n[LOG_FRAC];
        end
    end

    // radicand 2 ln / n, one quotient bit per stage
    for (genvar k = 0; k < RAD_W; k++) begin : g_div
        logic [VISIT_BITS:0] w_t;
        logic [VISIT_BITS:0] w_d;
        logic                w_ge;

        assign w_t  = {r_dv_rem[k], r_dv_dq[k][RAD_W-1]};
        assign w_ge = (w_t >= {1'b0, r_dv_n[k]});
        assign w_d  = w_t - {1'b0, r_dv_n[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[k+1] <= '0;
            end else if (i_adv) begin
                r_dv_ctl[k+1] <= r_dv_ctl[k];
                r_dv_rem[k+1] <= w_ge ? w_d[VISIT_BITS-1:0] : w_t[VISIT_BITS-1:0];
                r_dv_dq[k+1]  <= {r_dv_dq[k][RAD_W-2:0], w_ge};
                r_dv_n[k+1]   <= r_dv_n[k];
            end
        end
    end

    // floor square root, one root bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        logic [2*ROOT_W-1:0] w_x;
        logic [ROOT_W:0]     w_rem;
        logic [ROOT_W-1:0]   w_root;
        t_ctl                w_ctl;
        logic [ROOT_W+2:0]   w_t;
        logic [ROOT_W+2:0]   w_trial;
        logic [ROOT_W+2:0]   w_d;
        logic                w_ge;

        if (j == 0) begin : g_first
            assign w_x    = (2*ROOT_W)'(r_dv_dq[RAD_W]);
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_ctl  = r_dv_ctl[RAD_W];
        end else begin : g_next
            assign w_x    = r_sr_x[j];
            assign w_rem  = r_sr_rem[j];
            assign w_root = r_sr_root[j];
            assign w_ctl  = r_sr_ctl[j];
        end

        assign w_t     = {w_rem, w_x[2*ROOT_W-1:2*ROOT_W-2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_ge    = (w_t >= w_trial);
        assign w_d     = w_t - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_ctl[j+1] <= '0;
            end else if (i_adv) begin
                r_sr_ctl[j+1]  <= w_ctl;
                r_sr_x[j+1]    <= {w_x[2*ROOT_W-3:0], 2'b00};
                r_sr_rem[j+1]  <= w_ge ? w_d[ROOT_W:0] : w_t[ROOT_W:0];
                r_sr_root[j+1] <= {w_root[ROOT_W-2:0], w_ge};
            end
        end
    end

    // scale by the exploration weight
    assign w_tp = i_explore_weight * r_sr_root[ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_ctl <= '0;
        end else if (i_adv) begin
            r_term_ctl <= r_sr_ctl[ROOT_W];
            r_term     <= w_tp[CFG_W+ROOT_W-1 -: TERM_W];
        end
    end

    assign o_ctl  = r_term_ctl;
    assign o_term = r_term;

endmodule

// ----- rtl/core/uct_rave_node_score_unit.sv -----
// Each accepted word passes the explore pipe, then r_b1, r_b2 and the output register.
// Throughput: one word per cycle; the exploration path sets the depth (24 log squaring
// stages, 54 divider stages, 27 root stages); a stalled output freezes the whole pipe.
// Reset: synchronous, active low; clears all valid bits and loads C = 1638 and K = 50.
// Depends on urns_pkg, urns_explore_pipe, urns_mean_pipe, urns_beta_pipe.
module uct_rave_node_score_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input word
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [urns_pkg::DATA_W-1:0]     i_child_score,
    input  logic [urns_pkg::VISIT_BITS-1:0]        i_child_visits,
    input  logic [urns_pkg::VISIT_BITS-1:0]        i_parent_visits,
    input  logic signed [urns_pkg::DATA_W-1:0]     i_amaf_reward,
    input  logic [urns_pkg::VISIT_BITS-1:0]        i_amaf_visits,
    // result word
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [urns_pkg::DATA_W-1:0]     o_node_value,
    output logic                                   o_zero_visits_flag,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [urns_pkg::APB_AW-1:0]            paddr,
    input  logic [urns_pkg::APB_DW-1:0]            pwdata,
    output logic [urns_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import urns_pkg::*;

    logic w_adv;
    t_ctl w_in_ctl;
    t_ctl w_exp_ctl;
    logic [TERM_W-1:0] w_term;
    logic signed [DATA_W-1:0] w_score_mean;
    logic signed [DATA_W-1:0] w_reward_mean;
    logic [BETA_FRAC-1:0] w_beta;

    logic [CFG_W-1:0] r_explore_weight;
    logic [CFG_W-1:0] r_rave_k;

    logic signed [DATA_W-1:0] r_dl_sm   [0:MEAN_DLY-1];
    logic signed [DATA_W-1:0] r_dl_rm   [0:MEAN_DLY-1];
    logic [BETA_FRAC-1:0]     r_dl_beta [0:BETA_DLY-1];

    t_ctl                     r_b1_ctl;
    logic signed [Q_W-1:0]    r_b1_q;
    logic signed [DATA_W-1:0] r_b1_a;
    logic [BETA_W-1:0]        r_b1_omb;
    logic [BETA_FRAC-1:0]     r_b1_beta;

    t_ctl                     r_b2_ctl;
    logic signed [P1_W-1:0]   r_b2_p1;
    logic signed [P2_W-1:0]   r_b2_p2;

    t_ctl                     r_out_ctl;
    logic signed [DATA_W-1:0] r_out_value;

    logic signed [ACC_W-1:0]    w_acc;
    logic signed [SH_OUT_W-1:0] w_shr;
    logic [DATA_W-1:0]          n_value;

    // pipe advances unless a finished word is held at the output
    assign w_adv   = !(r_out_ctl.valid && i_stall);
    assign o_stall = !w_adv;

    assign w_in_ctl.valid = i_valid;
    assign w_in_ctl.zero  = (i_child_visits == '0) || (i_parent_visits == '0)
                         || (i_amaf_visits == '0);

    // config registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_explore_weight <= EXPLORE_WEIGHT_RST;
            r_rave_k         <= RAVE_K_RST;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[2]))
                REG_EXPLORE_WEIGHT: r_explore_weight <= pwdata[CFG_W-1:0];
                REG_RAVE_K:         r_rave_k         <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_EXPLORE_WEIGHT: prdata = APB_DW'(r_explore_weight);
            REG_RAVE_K:         prdata = APB_DW'(r_rave_k);
            default:            prdata = '0;
        endcase
    end

    // three parallel paths
    urns_explore_pipe u_explore (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_ctl            (w_in_ctl),
        .i_child_visits   (i_child_visits),
        .i_parent_visits  (i_parent_visits),
        .i_explore_weight (r_explore_weight),
        .o_ctl            (w_exp_ctl),
        .o_term           (w_term)
    );

    urns_mean_pipe u_mean (
        .i_clk          (i_clk),
        .i_adv          (w_adv),
        .i_child_score  (i_child_score),
        .i_child_visits (i_child_visits),
        .i_amaf_reward  (i_amaf_reward),
        .i_amaf_visits  (i_amaf_visits),
        .o_score_mean   (w_score_mean),
        .o_reward_mean  (w_reward_mean)
    );

    urns_beta_pipe u_beta (
        .i_clk           (i_clk),
        .i_adv           (w_adv),
        .i_parent_visits (i_parent_visits),
        .i_rave_k        (r_rave_k),
        .o_beta          (w_beta)
    );

    // align the shorter paths with the exploration term
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl_sm[0]   <= w_score_mean;
            r_dl_rm[0]   <= w_reward_mean;
            r_dl_beta[0] <= w_beta;
            for (int k = 1; k < MEAN_DLY; k++) begin
                r_dl_sm[k] <= r_dl_sm[k-1];
                r_dl_rm[k] <= r_dl_rm[k-1];
            end
            for (int k = 1; k < BETA_DLY; k++) begin
                r_dl_beta[k] <= r_dl_beta[k-1];
            end
        end
    end

    // uct value and one minus beta
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_ctl <= '0;
        end else if (w_adv) begin
            r_b1_ctl  <= w_exp_ctl;
            r_b1_q    <= $signed({{(Q_W-DATA_W){r_dl_sm[MEAN_DLY-1][DATA_W-1]}},
                                  r_dl_sm[MEAN_DLY-1]})
                       + $signed({{(Q_W-TERM_W){1'b0}}, w_term});
            r_b1_a    <= r_dl_rm[MEAN_DLY-1];
            r_b1_omb  <= {1'b1, {BETA_FRAC{1'b0}}} - {1'b0, r_dl_beta[BETA_DLY-1]};
            r_b1_beta <= r_dl_beta[BETA_DLY-1];
        end
    end

    // weighted products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_ctl <= '0;
        end else if (w_adv) begin
            r_b2_ctl <= r_b1_ctl;
            r_b2_p1  <= $signed({1'b0, r_b1_omb}) * r_b1_q;
            r_b2_p2  <= $signed({1'b0, r_b1_beta}) * r_b1_a;
        end
    end

    // round half up, floor shift, saturate; zero for a zero-visit word
    assign w_acc = $signed({r_b2_p1[P1_W-1], r_b2_p1})
                 + $signed({{(ACC_W-P2_W){r_b2_p2[P2_W-1]}}, r_b2_p2})
                 + $signed(ACC_W'(1) << (BETA_FRAC - 1));
    assign w_shr = w_acc[ACC_W-1:BETA_FRAC];

    always_comb begin
        if (r_b2_ctl.zero) begin
            n_value = '0;
        end else if ((w_shr[SH_OUT_W-1:DATA_W-1] != '0)
                  && (w_shr[SH_OUT_W-1:DATA_W-1] != '1)) begin
            n_value = w_shr[SH_OUT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            n_value = w_shr[DATA_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else if (w_adv) begin
            r_out_ctl   <= r_b2_ctl;
            r_out_value <= $signed(n_value);
        end
    end

    assign o_valid            = r_out_ctl.valid;
    assign o_zero_visits_flag = r_out_ctl.zero;
    assign o_node_value       = r_out_value;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for uct_rave_node_score_unit, blended uct/rave value with apb setup
// depends on urns_pkg and the rtl in rtl/core; predicts each word in fixed point and compares
`timescale 1ns / 100ps

module tb;
    import urns_pkg::*;

    typedef struct {
        logic signed [31:0] score;
        logic [23:0]        child_n;
        logic [23:0]        parent_n;
        logic signed [31:0] reward;
        logic [23:0]        amaf_n;
    } t_child;

    typedef struct {
        logic signed [31:0] value;
        logic               zero;
    } t_score;

    localparam int LATENCY = 111;
    localparam int WDOG_LIMIT = 4000;
    localparam logic [63:0] LN2_C = 64'd2977044472;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [31:0] i_child_score, i_amaf_reward, o_node_value;
    logic [23:0] i_child_visits, i_parent_visits, i_amaf_visits;
    logic o_zero_visits_flag;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    t_child pending_q[$];
    t_score expected_q[$];
    logic [15:0] cur_c, cur_k;
    int errors;
    int idle_left_tx, idle_left_rx, hold_rx;
    bit idle_en, hold_req;
    int wdog;

    uct_rave_node_score_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor square root of a 64-bit value
    function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in q5.24 by repeated squaring of the mantissa
    function automatic logic [63:0] log2_fixed(input logic [63:0] v);
        int p;
        logic [63:0] x, frac;
        p = 0;
        frac = 0;
        while (p < 31 && (v >> (p + 1)) != 0) p++;
        x = v << (31 - p);
        for (int i = 0; i < 24; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32)) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(p) << 24) | frac;
    endfunction

    function automatic t_score node_value_of(input t_child c);
        t_score s;
        logic [63:0] lnq, rad, root, term, beta, bden;
        longint q, a, acc, r;
        s.value = 0;
        s.zero = 1'b1;
        if (c.child_n == 0 || c.parent_n == 0 || c.amaf_n == 0) return s;
        lnq = (log2_fixed(64'(c.parent_n)) * LN2_C) >> 24;
        rad = (lnq << 17) / 64'(c.child_n);
        root = sqrt_floor(rad);
        term = (64'(cur_c) * root) >> (36 - FRAC_BITS);
        q = longint'(c.score) / longint'(c.child_n) + longint'(term);
        a = longint'(c.reward) / longint'(c.amaf_n);
        bden = 3 * 64'(c.parent_n) + 64'(cur_k);
        beta = sqrt_floor((64'(cur_k) << 48) / bden);
        if (beta > (64'd1 << 24)) beta = 64'd1 << 24;
        acc = longint'((64'd1 << 24) - beta) * q + longint'(beta) * a + (longint'(1) << 23);
        r = acc >>> 24;
        if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
        if (r < -64'sh80000000) r = -64'sh80000000;
        s.value = r[31:0];
        s.zero = 1'b0;
        return s;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_EXPLORE_WEIGHT) cur_c = val;
        else cur_k = val;
    endtask

    function automatic logic [23:0] rand_visits();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(1, 4));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 3));
            2: return 24'($urandom_range(1, 1000));
            3: return ($urandom_range(0, 30) == 0) ? 24'd0 : 24'($urandom);
            default: return 24'($urandom) | 24'd1;
        endcase
    endfunction

    function automatic t_child rand_child();
        t_child c;
        c.score = $urandom;
        c.reward = $urandom;
        c.child_n = rand_visits();
        c.parent_n = rand_visits();
        c.amaf_n = rand_visits();
        return c;
    endfunction

    // fill the queue and wait for it to drain with every result in
    task automatic run_words(input int count);
        repeat (count) pending_q.push_back(rand_child());
        wait (pending_q.size() == 0 && !i_valid && expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // driver: pops pending children onto the input port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) expected_q.push_back(node_value_of('{i_child_score, i_child_visits,
                i_parent_visits, i_amaf_reward, i_amaf_visits}));
            if (idle_left_tx > 0) begin
                idle_left_tx <= idle_left_tx - 1;
                i_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                idle_left_tx <= $urandom_range(1, 14);
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                t_child c;
                c = pending_q.pop_front();
                i_valid <= 1'b1;
                i_child_score <= c.score;
                i_child_visits <= c.child_n;
                i_parent_visits <= c.parent_n;
                i_amaf_reward <= c.reward;
                i_amaf_visits <= c.amaf_n;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each result word with the oldest prediction, drives stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected word", o_node_value, 0);
                end else begin
                    t_score e;
                    e = expected_q.pop_front();
                    if (o_node_value !== e.value) report("node_value", o_node_value, e.value);
                    if (o_zero_visits_flag !== e.zero)
                        report("zero_visits_flag", 32'(o_zero_visits_flag), 32'(e.zero));
                end
            end
            if (hold_req && hold_rx == 0) begin
                hold_rx <= 600;
                hold_req <= 1'b0;
                i_stall <= 1'b1;
            end else if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                i_stall <= (hold_rx > 1);
            end else if (idle_left_rx > 0) begin
                idle_left_rx <= idle_left_rx - 1;
                i_stall <= (idle_left_rx > 1);
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                idle_left_rx <= $urandom_range(1, 14);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || psel) wdog <= 0;
        else if (pending_q.size() > 0 || expected_q.size() > 0 || i_valid) begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_child c;
        logic [23:0] vals [5];
        errors = 0;
        idle_left_tx = 0;
        idle_left_rx = 0;
        hold_rx = 0;
        hold_req = 1'b0;
        idle_en = 1'b1;
        wdog = 0;
        cur_c = EXPLORE_WEIGHT_RST;
        cur_k = RAVE_K_RST;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_child_score = 0;
        i_child_visits = 0;
        i_parent_visits = 0;
        i_amaf_reward = 0;
        i_amaf_visits = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 0;
        pwdata = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero visits on each count, extremes, parent of one
        vals = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'd100};
        for (int i = 0; i < 5; i++) begin
            c.score = (i % 2) ? 32'sh7FFFFFFF : -32'sh80000000;
            c.reward = (i % 2) ? -32'sh80000000 : 32'sh7FFFFFFF;
            c.child_n = vals[i];
            c.parent_n = vals[(i + 1) % 5];
            c.amaf_n = vals[(i + 2) % 5];
            pending_q.push_back(c);
        end
        pending_q.push_back('{32'sh7FFFFFFF, 24'd1, 24'hFFFFFF, 32'sh7FFFFFFF, 24'd1});
        pending_q.push_back('{-32'sh80000000, 24'd1, 24'd1, -32'sh80000000, 24'd1});
        pending_q.push_back('{32'sh00010000, 24'd1, 24'd1, 32'sh00008000, 24'd3});
        pending_q.push_back('{32'sh0, 24'hFFFFFF, 24'hFFFFFF, 32'sh0, 24'hFFFFFF});
        run_words(20);

        // large and zero c, k extremes, with a long receiver hold at the start of the first run
        apb_write(REG_EXPLORE_WEIGHT, 16'hFFFF);
        apb_write(REG_RAVE_K, 16'hFFFF);
        hold_req = 1'b1;
        run_words(300);
        apb_write(REG_EXPLORE_WEIGHT, 16'd0);
        apb_write(REG_RAVE_K, 16'd1);
        run_words(300);
        apb_write(REG_EXPLORE_WEIGHT, 16'($urandom));
        apb_write(REG_RAVE_K, 16'($urandom_range(1, 65535)));
        run_words(350);
        apb_write(REG_EXPLORE_WEIGHT, EXPLORE_WEIGHT_RST);
        apb_write(REG_RAVE_K, RAVE_K_RST);
        run_words(200);
        // last stretch without idling
        idle_en = 1'b0;
        run_words(200);

        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
